@@ hw/rtl/scc_pkg.sv @@
// ----------------------------------------------------------------------------
// scc_pkg
// Shared widths, register indexes and control types of the smoothed
// three-point circumcircle unit.
// ----------------------------------------------------------------------------
package scc_pkg;

  // number formats
  localparam int FRAC_BITS  = 8;
  localparam int PIXEL_BITS = 10;
  localparam int COORD_W    = PIXEL_BITS + FRAC_BITS;   // point coordinate
  localparam int DIFF_W     = COORD_W + 1;              // offset from the root
  localparam int NORM_W     = 2 * COORD_W + 2;          // squared distance
  localparam int HALF_W     = NORM_W / 2;               // split of a squared distance
  localparam int OUT_W      = 24;                       // center and radius
  localparam int CDIFF_W    = OUT_W + 2;                // circle smoother difference
  localparam int ROOT_W     = 10;
  localparam int GAIN_W     = 17;
  localparam int GAIN_SHIFT = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = GAIN_W;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_X      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_Y      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_GAIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CIRCLE_GAIN = 2'd3;
  localparam logic [ROOT_W-1:0] ROOT_X_RST = 10'd202;
  localparam logic [ROOT_W-1:0] ROOT_Y_RST = 10'd269;
  localparam logic [GAIN_W-1:0] GAIN_RST   = 17'd6554;
  localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'd65536;

  // multiply-accumulate unit
  localparam int MUL_W  = 27;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 64;
  localparam logic signed [ACC_W-1:0] RND_HALF = 64'sd32768;

  // divider
  localparam int DET_W   = 40;
  localparam int DIVN_W  = 60;
  localparam int DCNT_W  = 6;
  localparam int REM_W   = DET_W + 1;
  localparam int OFS_W   = 42;
  localparam logic [DIVN_W-1:0] OFS_LIMIT = 60'd1 << 40;

  // radius and center limits
  localparam logic signed [OFS_W-1:0] RAD_CLAMP_POS = 42'sd33554432;
  localparam logic signed [OFS_W-1:0] RAD_CLAMP_NEG = -42'sd33554432;
  localparam int CSUM_W = OFS_W + 2;
  localparam logic signed [CSUM_W-1:0] C24_MAX = 44'sd8388607;
  localparam logic signed [CSUM_W-1:0] C24_MIN = -44'sd8388608;

  // square root
  localparam int SQ_W = 52;
  localparam int RT_W = 27;
  localparam logic [RT_W-1:0] R24_MAX = 27'd16777215;

  typedef struct packed {
    logic en;    // update the accumulator
    logic clr;   // start from zero
    logic sub;   // subtract the product
    logic shl;   // product weighted by the upper half
  } mac_ctl_t;

endpackage

@@ hw/rtl/smoothed_three_point_circumcircle_unit.sv @@
// ----------------------------------------------------------------------------
// smoothed_three_point_circumcircle_unit
// Smooths a top and a mid point, fits the circle through them and a fixed
// root point, and smooths the center and radius.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. An item passes from acceptance
// to a valid result through these steps: smoothing the points on the
// shared multiply-accumulate unit, the squared norms, determinant and
// numerators, two divisions in the one-bit-per-cycle divider, the squared
// offset and the 26-step square root, and the circle smoother. With collinear
// points the divisions and the root are skipped. in_tready is high only while
// the unit is idle; a result is held on the output until it is taken, and the
// unit is idle again in the cycle after that.
// Configuration writes are taken at any time and should land while idle.
module smoothed_three_point_circumcircle_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // input items
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [71:0]                        in_tdata,   // top_x, top_y, mid_x, mid_y
  // results
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [71:0]                        out_tdata,  // ctr_x, ctr_y, radius
  output logic [0:0]                         out_tuser,  // collinear
  // configuration
  input  logic                               cfg_we,
  input  logic [scc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [scc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int CW = scc_pkg::COORD_W;
  localparam int OW = scc_pkg::OUT_W;
  localparam int MW = scc_pkg::MUL_W;
  localparam logic [1:0] IDX_LAST_PT = 2'd3;
  localparam logic [1:0] IDX_RAD     = 2'd2;
  localparam logic [3:0] STEP_LAST   = 4'd13;

  typedef enum logic [3:0] {
    S_IDLE, S_PMUL, S_PUPD, S_CALC, S_DIVX, S_DIVY,
    S_SQ0, S_SQ1, S_SQST, S_SQRT, S_CMUL, S_CUPD, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [3:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       col_r, col_nxt;

  logic [scc_pkg::ROOT_W-1:0] root_x_r, root_x_nxt, root_y_r, root_y_nxt;
  logic [scc_pkg::GAIN_W-1:0] pgain_r, pgain_nxt, cgain_r, cgain_nxt;

  logic [CW-1:0] raw_r [4];
  logic [CW-1:0] raw_nxt [4];
  logic [CW-1:0] sp_r [4];
  logic [CW-1:0] sp_nxt [4];
  logic [OW-1:0] sc_r [3];
  logic [OW-1:0] sc_nxt [3];
  logic [OW-1:0] rawc_r [3];
  logic [OW-1:0] rawc_nxt [3];

  logic [scc_pkg::NORM_W-1:0]        na_r, na_nxt, nb_r, nb_nxt;
  logic signed [scc_pkg::DET_W-1:0]  det_r, det_nxt;
  logic signed [scc_pkg::ACC_W-1:0]  numx_r, numx_nxt;
  logic signed [scc_pkg::OFS_W-1:0]  ox_r, ox_nxt, oy_r, oy_nxt;

  // shared unit connections
  scc_pkg::mac_ctl_t                 mac_ctl;
  logic signed [MW-1:0]              mac_a, mac_b;
  logic signed [scc_pkg::ACC_W-1:0]  acc;
  logic                              div_start, div_done;
  logic signed [scc_pkg::ACC_W-1:0]  div_num;
  logic signed [scc_pkg::OFS_W-1:0]  div_quot;
  logic                              sq_start, sq_done;
  logic [scc_pkg::RT_W-1:0]          sq_root;

  // derived operands
  logic [CW-1:0]                  rx, ry;
  logic [scc_pkg::GAIN_W-1:0]     pg, cg;
  logic signed [MW-1:0]           pg_e, cg_e;
  logic signed [scc_pkg::DIFF_W-1:0] ax, ay, bx, by, pd;
  logic signed [MW-1:0]           ax_e, ay_e, bx_e, by_e, pd_e;
  logic signed [MW-1:0]           na_lo, na_hi, nb_lo, nb_hi;
  logic signed [MW-1:0]           qx, qy;
  logic signed [scc_pkg::CDIFF_W-1:0] cd;
  logic signed [MW-1:0]           cd_e;
  logic signed [scc_pkg::ACC_W-1:0] rnd;
  logic signed [scc_pkg::CSUM_W-1:0] csx, csy;
  logic [OW-1:0]                  cx_sat, cy_sat, rad_sat;
  logic                           ext_bit;

  scc_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (mac_b),
    .acc (acc)
  );

  scc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .det   (det_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  scc_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .s     (acc[scc_pkg::SQ_W-1:0]),
    .done  (sq_done),
    .root  (sq_root)
  );

  // offsets, gains and saturation
  always_comb begin
    rx = {root_x_r, {scc_pkg::FRAC_BITS{1'b0}}};
    ry = {root_y_r, {scc_pkg::FRAC_BITS{1'b0}}};
    pg = (pgain_r > scc_pkg::GAIN_ONE) ? scc_pkg::GAIN_ONE : pgain_r;
    cg = (cgain_r > scc_pkg::GAIN_ONE) ? scc_pkg::GAIN_ONE : cgain_r;
    pg_e = {{(MW - scc_pkg::GAIN_W){1'b0}}, pg};
    cg_e = {{(MW - scc_pkg::GAIN_W){1'b0}}, cg};

    ax = $signed({1'b0, sp_r[0]}) - $signed({1'b0, rx});
    ay = $signed({1'b0, sp_r[1]}) - $signed({1'b0, ry});
    bx = $signed({1'b0, sp_r[2]}) - $signed({1'b0, rx});
    by = $signed({1'b0, sp_r[3]}) - $signed({1'b0, ry});
    pd = $signed({1'b0, raw_r[idx_r]}) - $signed({1'b0, sp_r[idx_r]});
    ax_e = {{(MW - scc_pkg::DIFF_W){ax[scc_pkg::DIFF_W-1]}}, ax};
    ay_e = {{(MW - scc_pkg::DIFF_W){ay[scc_pkg::DIFF_W-1]}}, ay};
    bx_e = {{(MW - scc_pkg::DIFF_W){bx[scc_pkg::DIFF_W-1]}}, bx};
    by_e = {{(MW - scc_pkg::DIFF_W){by[scc_pkg::DIFF_W-1]}}, by};
    pd_e = {{(MW - scc_pkg::DIFF_W){pd[scc_pkg::DIFF_W-1]}}, pd};

    na_lo = {{(MW - scc_pkg::HALF_W){1'b0}}, na_r[scc_pkg::HALF_W-1:0]};
    na_hi = {{(MW - scc_pkg::HALF_W){1'b0}}, na_r[scc_pkg::NORM_W-1:scc_pkg::HALF_W]};
    nb_lo = {{(MW - scc_pkg::HALF_W){1'b0}}, nb_r[scc_pkg::HALF_W-1:0]};
    nb_hi = {{(MW - scc_pkg::HALF_W){1'b0}}, nb_r[scc_pkg::NORM_W-1:scc_pkg::HALF_W]};

    // offsets clamped for the radius
    if (ox_r > scc_pkg::RAD_CLAMP_POS)      qx = scc_pkg::RAD_CLAMP_POS[MW-1:0];
    else if (ox_r < scc_pkg::RAD_CLAMP_NEG) qx = scc_pkg::RAD_CLAMP_NEG[MW-1:0];
    else                                    qx = ox_r[MW-1:0];
    if (oy_r > scc_pkg::RAD_CLAMP_POS)      qy = scc_pkg::RAD_CLAMP_POS[MW-1:0];
    else if (oy_r < scc_pkg::RAD_CLAMP_NEG) qy = scc_pkg::RAD_CLAMP_NEG[MW-1:0];
    else                                    qy = oy_r[MW-1:0];

    // circle smoother difference, radius is unsigned
    ext_bit = (idx_r != IDX_RAD) & rawc_r[idx_r][OW-1];
    cd = $signed({ext_bit, ext_bit, rawc_r[idx_r]})
       - $signed({(idx_r != IDX_RAD) & sc_r[idx_r][OW-1],
                  (idx_r != IDX_RAD) & sc_r[idx_r][OW-1], sc_r[idx_r]});
    cd_e = {{(MW - scc_pkg::CDIFF_W){cd[scc_pkg::CDIFF_W-1]}}, cd};

    rnd = (acc + scc_pkg::RND_HALF) >>> scc_pkg::GAIN_SHIFT;

    // absolute center, saturated to the output range
    csx = $signed({{(scc_pkg::CSUM_W - CW){1'b0}}, rx}) + {{2{ox_r[scc_pkg::OFS_W-1]}}, ox_r};
    csy = $signed({{(scc_pkg::CSUM_W - CW){1'b0}}, ry}) + {{2{oy_r[scc_pkg::OFS_W-1]}}, oy_r};
    if (csx > scc_pkg::C24_MAX)      cx_sat = scc_pkg::C24_MAX[OW-1:0];
    else if (csx < scc_pkg::C24_MIN) cx_sat = scc_pkg::C24_MIN[OW-1:0];
    else                             cx_sat = csx[OW-1:0];
    if (csy > scc_pkg::C24_MAX)      cy_sat = scc_pkg::C24_MAX[OW-1:0];
    else if (csy < scc_pkg::C24_MIN) cy_sat = scc_pkg::C24_MIN[OW-1:0];
    else                             cy_sat = csy[OW-1:0];
    rad_sat = (sq_root > scc_pkg::R24_MAX) ? scc_pkg::R24_MAX[OW-1:0] : sq_root[OW-1:0];

    div_num = (state_r == S_DIVX) ? acc : numx_r;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    col_nxt       = col_r;
    root_x_nxt    = root_x_r;
    root_y_nxt    = root_y_r;
    pgain_nxt     = pgain_r;
    cgain_nxt     = cgain_r;
    raw_nxt       = raw_r;
    sp_nxt        = sp_r;
    sc_nxt        = sc_r;
    rawc_nxt      = rawc_r;
    na_nxt        = na_r;
    nb_nxt        = nb_r;
    det_nxt       = det_r;
    numx_nxt      = numx_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    mac_ctl       = '0;
    mac_a         = '0;
    mac_b         = '0;
    div_start     = 1'b0;
    sq_start      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          raw_nxt[0] = in_tdata[CW-1:0];
          raw_nxt[1] = in_tdata[2*CW-1:CW];
          raw_nxt[2] = in_tdata[3*CW-1:2*CW];
          raw_nxt[3] = in_tdata[4*CW-1:3*CW];
          idx_nxt    = '0;
          state_nxt  = S_PMUL;
        end
      end
      // point smoother: gain times difference, then rounded update
      S_PMUL: begin
        mac_ctl   = '{en: 1'b1, clr: 1'b1, sub: 1'b0, shl: 1'b0};
        mac_a     = pg_e;
        mac_b     = pd_e;
        state_nxt = S_PUPD;
      end
      S_PUPD: begin
        sp_nxt[idx_r] = sp_r[idx_r] + rnd[CW-1:0];
        if (idx_r == IDX_LAST_PT) begin
          step_nxt  = '0;
          state_nxt = S_CALC;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_PMUL;
        end
      end
      // norms, determinant and numerators on the shared unit
      S_CALC: begin
        mac_ctl.en = 1'b1;
        step_nxt   = step_r + 1'b1;
        case (step_r)
          4'd0:  begin mac_ctl.clr = 1'b1; mac_a = ax_e; mac_b = ax_e; end
          4'd1:  begin mac_a = ay_e; mac_b = ay_e; end
          4'd2:  begin
            na_nxt = acc[scc_pkg::NORM_W-1:0];
            mac_ctl.clr = 1'b1; mac_a = bx_e; mac_b = bx_e;
          end
          4'd3:  begin mac_a = by_e; mac_b = by_e; end
          4'd4:  begin
            nb_nxt = acc[scc_pkg::NORM_W-1:0];
            mac_ctl.clr = 1'b1; mac_a = ax_e; mac_b = by_e;
          end
          4'd5:  begin mac_ctl.sub = 1'b1; mac_a = ay_e; mac_b = bx_e; end
          4'd6:  begin
            det_nxt = {acc[scc_pkg::DET_W-2:0], 1'b0};
            mac_ctl.clr = 1'b1; mac_a = by_e; mac_b = na_lo;
          end
          4'd7:  begin mac_ctl.shl = 1'b1; mac_a = by_e; mac_b = na_hi; end
          4'd8:  begin mac_ctl.sub = 1'b1; mac_a = ay_e; mac_b = nb_lo; end
          4'd9:  begin
            mac_ctl.sub = 1'b1; mac_ctl.shl = 1'b1; mac_a = ay_e; mac_b = nb_hi;
          end
          4'd10: begin
            numx_nxt = acc;
            mac_ctl.clr = 1'b1; mac_a = ax_e; mac_b = nb_lo;
          end
          4'd11: begin mac_ctl.shl = 1'b1; mac_a = ax_e; mac_b = nb_hi; end
          4'd12: begin mac_ctl.sub = 1'b1; mac_a = bx_e; mac_b = na_lo; end
          4'd13: begin
            mac_ctl.sub = 1'b1; mac_ctl.shl = 1'b1; mac_a = bx_e; mac_b = na_hi;
          end
          default: begin
            mac_ctl.en = 1'b0;
          end
        endcase
        if (step_r == STEP_LAST) begin
          col_nxt = (det_r == '0);
          if (det_r == '0) begin
            // collinear: the previous smoothed circle stands
            rawc_nxt  = sc_r;
            idx_nxt   = '0;
            state_nxt = S_CMUL;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIVX;
          end
        end
      end
      S_DIVX: begin
        if (div_done) begin
          ox_nxt    = div_quot;
          div_start = 1'b1;
          state_nxt = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_done) begin
          oy_nxt    = div_quot;
          state_nxt = S_SQ0;
        end
      end
      // squared offset for the radius
      S_SQ0: begin
        mac_ctl   = '{en: 1'b1, clr: 1'b1, sub: 1'b0, shl: 1'b0};
        mac_a     = qx;
        mac_b     = qx;
        state_nxt = S_SQ1;
      end
      S_SQ1: begin
        mac_ctl   = '{en: 1'b1, clr: 1'b0, sub: 1'b0, shl: 1'b0};
        mac_a     = qy;
        mac_b     = qy;
        state_nxt = S_SQST;
      end
      S_SQST: begin
        sq_start  = 1'b1;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (sq_done) begin
          rawc_nxt[0] = cx_sat;
          rawc_nxt[1] = cy_sat;
          rawc_nxt[2] = rad_sat;
          idx_nxt     = '0;
          state_nxt   = S_CMUL;
        end
      end
      // circle smoother
      S_CMUL: begin
        mac_ctl   = '{en: 1'b1, clr: 1'b1, sub: 1'b0, shl: 1'b0};
        mac_a     = cg_e;
        mac_b     = cd_e;
        state_nxt = S_CUPD;
      end
      S_CUPD: begin
        sc_nxt[idx_r] = sc_r[idx_r] + rnd[OW-1:0];
        if (idx_r == IDX_RAD) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_CMUL;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // configuration writes
    if (cfg_we) begin
      case (cfg_index)
        scc_pkg::CFG_ROOT_X:      root_x_nxt = cfg_wdata[scc_pkg::ROOT_W-1:0];
        scc_pkg::CFG_ROOT_Y:      root_y_nxt = cfg_wdata[scc_pkg::ROOT_W-1:0];
        scc_pkg::CFG_POINT_GAIN:  pgain_nxt  = cfg_wdata;
        scc_pkg::CFG_CIRCLE_GAIN: cgain_nxt  = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // state, smoother state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      col_r       <= 1'b0;
      root_x_r    <= scc_pkg::ROOT_X_RST;
      root_y_r    <= scc_pkg::ROOT_Y_RST;
      pgain_r     <= scc_pkg::GAIN_RST;
      cgain_r     <= scc_pkg::GAIN_RST;
      for (int i = 0; i < 4; i++) begin
        sp_r[i] <= '0;
      end
      for (int j = 0; j < 3; j++) begin
        sc_r[j] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      col_r       <= col_nxt;
      root_x_r    <= root_x_nxt;
      root_y_r    <= root_y_nxt;
      pgain_r     <= pgain_nxt;
      cgain_r     <= cgain_nxt;
      sp_r        <= sp_nxt;
      sc_r        <= sc_nxt;
    end
    raw_r  <= raw_nxt;
    rawc_r <= rawc_nxt;
    na_r   <= na_nxt;
    nb_r   <= nb_nxt;
    det_r  <= det_nxt;
    numx_r <= numx_nxt;
    ox_r   <= ox_nxt;
    oy_r   <= oy_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {sc_r[2], sc_r[1], sc_r[0]};
  assign out_tuser  = col_r;

endmodule

@@ hw/rtl/scc_mac.sv @@
// ----------------------------------------------------------------------------
// scc_mac
// Shared signed multiply-accumulate unit, one product per cycle while ctl.en is set.
// ----------------------------------------------------------------------------
module scc_mac (
  input  logic                                  clk,
  input  scc_pkg::mac_ctl_t                     ctl,
  input  logic signed [scc_pkg::MUL_W-1:0]      a,
  input  logic signed [scc_pkg::MUL_W-1:0]      b,
  output logic signed [scc_pkg::ACC_W-1:0]      acc
);

  logic signed [scc_pkg::PROD_W-1:0] prod;
  logic signed [scc_pkg::ACC_W-1:0]  term;
  logic signed [scc_pkg::ACC_W-1:0]  base;
  logic signed [scc_pkg::ACC_W-1:0]  acc_r;
  logic signed [scc_pkg::ACC_W-1:0]  acc_nxt;

  // product, optional weighting, accumulate
  always_comb begin
    prod = a * b;
    term = {{(scc_pkg::ACC_W - scc_pkg::PROD_W){prod[scc_pkg::PROD_W-1]}}, prod};
    if (ctl.shl) begin
      term = term <<< scc_pkg::HALF_W;
    end
    base    = ctl.clr ? '0 : acc_r;
    acc_nxt = ctl.sub ? base - term : base + term;
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

@@ hw/rtl/scc_div.sv @@
// ----------------------------------------------------------------------------
// scc_div
// Restoring divider, one quotient bit per cycle, giving the rounded and
// clamped center offset num/det.
// ----------------------------------------------------------------------------
module scc_div (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [scc_pkg::ACC_W-1:0]      num,
  input  logic signed [scc_pkg::DET_W-1:0]      det,
  output logic                                  done,
  output logic signed [scc_pkg::OFS_W-1:0]      quot
);

  logic [scc_pkg::DIVN_W-1:0] n_r, n_nxt;
  logic [scc_pkg::REM_W-1:0]  rem_r, rem_nxt;
  logic [scc_pkg::REM_W-1:0]  dvs_r, dvs_nxt;
  logic [scc_pkg::DCNT_W-1:0] cnt_r, cnt_nxt;
  logic                       neg_r, neg_nxt;
  logic                       done_r, done_nxt;

  logic [scc_pkg::ACC_W-1:0]  mag_num;
  logic [scc_pkg::DET_W-1:0]  mag_det;
  logic [scc_pkg::REM_W-1:0]  rem_sh;
  logic                       fits;
  logic [scc_pkg::DIVN_W-1:0] qmag;

  always_comb begin
    mag_num  = num[scc_pkg::ACC_W-1] ? 64'(-num) : 64'(num);
    mag_det  = det[scc_pkg::DET_W-1] ? 40'(-det) : 40'(det);
    rem_sh   = {rem_r[scc_pkg::REM_W-2:0], n_r[scc_pkg::DIVN_W-1]};
    fits     = rem_sh >= dvs_r;

    n_nxt    = n_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;

    if (start) begin
      // dividend 2|num| + |det|, divisor 2|det| rounds ties away from zero
      n_nxt   = {mag_num[scc_pkg::DIVN_W-2:0], 1'b0}
              + {{(scc_pkg::DIVN_W - scc_pkg::DET_W){1'b0}}, mag_det};
      rem_nxt = '0;
      dvs_nxt = {mag_det, 1'b0};
      neg_nxt = num[scc_pkg::ACC_W-1] ^ det[scc_pkg::DET_W-1];
      cnt_nxt = scc_pkg::DCNT_W'(scc_pkg::DIVN_W);
    end else if (cnt_r != '0) begin
      // one quotient bit, shifted in at the bottom
      rem_nxt = fits ? rem_sh - dvs_r : rem_sh;
      n_nxt   = {n_r[scc_pkg::DIVN_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      done_nxt = (cnt_r == scc_pkg::DCNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  // clamp the magnitude and apply the sign
  always_comb begin
    qmag = (n_r > scc_pkg::OFS_LIMIT) ? scc_pkg::OFS_LIMIT : n_r;
    quot = neg_r ? -$signed(qmag[scc_pkg::OFS_W-1:0]) : $signed(qmag[scc_pkg::OFS_W-1:0]);
  end

  assign done = done_r;

endmodule

@@ hw/rtl/scc_sqrt.sv @@
// ----------------------------------------------------------------------------
// scc_sqrt
// Digit-by-digit integer square root, one result bit per cycle, rounded to
// nearest at the end.
// ----------------------------------------------------------------------------
module scc_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [scc_pkg::SQ_W-1:0]      s,
  output logic                          done,
  output logic [scc_pkg::RT_W-1:0]      root
);

  logic [scc_pkg::SQ_W-1:0] x_r, x_nxt;
  logic [scc_pkg::SQ_W-1:0] r_r, r_nxt;
  logic [scc_pkg::SQ_W-1:0] bit_r, bit_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [scc_pkg::SQ_W-1:0] trial;

  always_comb begin
    trial    = r_r + bit_r;
    x_nxt    = x_r;
    r_nxt    = r_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;

    if (start) begin
      x_nxt    = s;
      r_nxt    = '0;
      bit_nxt  = {2'b01, {(scc_pkg::SQ_W-2){1'b0}}};
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // one root bit per step
      if (x_r >= trial) begin
        x_nxt = x_r - trial;
        r_nxt = (r_r >> 1) + bit_r;
      end else begin
        r_nxt = r_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r   <= x_nxt;
    r_r   <= r_nxt;
    bit_r <= bit_nxt;
  end

  // the remainder is s - r*r, so round up when it exceeds r
  assign root = r_r[scc_pkg::RT_W-1:0] + scc_pkg::RT_W'(x_r > r_r);
  assign done = done_r;

endmodule

@@ test/tb_smoothed_three_point_circumcircle_unit.sv @@
// ----------------------------------------------------------------------------
// tb_smoothed_three_point_circumcircle_unit
// Drives top and mid points into the circumcircle unit under random gaps and
// output stalls, predicts each smoothed circle in wide integer arithmetic and
// compares every result field in order.
// ----------------------------------------------------------------------------
module tb_smoothed_three_point_circumcircle_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [23:0] cx;
    logic [23:0] cy;
    logic [23:0] rad;
    logic        col;
  } circle_t;

  localparam longint COORD_MAX = 262143;
  localparam longint OFS_LIM   = 64'd1 << 40;
  localparam longint RAD_LIM   = 64'd1 << 25;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [71:0] in_tdata = '0;     // top_x, top_y, mid_x, mid_y
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [71:0] out_tdata;         // ctr_x, ctr_y, radius
  logic [0:0] out_tuser;          // collinear
  logic cfg_we = 1'b0;
  logic [scc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [scc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor state and its copy of the registers
  longint root_x_q, root_y_q, pt_gain_q, cir_gain_q;
  longint s_top_x, s_top_y, s_mid_x, s_mid_y, s_cx, s_cy, s_rad;
  circle_t circles_due[$];
  int fails = 0;
  int hold_cycles = 0;
  bit calm = 1'b0;

  smoothed_three_point_circumcircle_unit u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #40ms;
    $display("tb_smoothed_three_point_circumcircle_unit NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint smooth_step(longint old, longint raw, longint gain);
    longint g;
    g = (gain > 65536) ? 65536 : gain;
    return old + ((g * (raw - old) + 32768) >>> 16);
  endfunction

  // nearest quotient, ties away from zero, magnitude limited to 2^40
  function automatic longint div_nearest(logic signed [127:0] num, longint den);
    logic [127:0] m, d, q;
    longint mag;
    m = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (2 * m + d) / (2 * d);
    mag = (q > OFS_LIM) ? OFS_LIM : longint'(q);
    return ((num < 0) != (den < 0)) ? -mag : mag;
  endfunction

  function automatic longint root_nearest(longint unsigned s);
    longint unsigned r, t;
    r = 0;
    for (int b = 27; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= s) r = t;
    end
    if (s - r * r > r) r++;
    return longint'(r);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic circle_t predict_circle(logic [71:0] pts);
    longint rx, ry, ax, ay, bx, by, na, nb, det, cx, cy, rad, ox, oy, qx, qy;
    logic signed [127:0] wax, way, wbx, wby, wna, wnb;
    circle_t c;
    rx = root_x_q << scc_pkg::FRAC_BITS;
    ry = root_y_q << scc_pkg::FRAC_BITS;
    s_top_x = smooth_step(s_top_x, pts[17:0], pt_gain_q);
    s_top_y = smooth_step(s_top_y, pts[35:18], pt_gain_q);
    s_mid_x = smooth_step(s_mid_x, pts[53:36], pt_gain_q);
    s_mid_y = smooth_step(s_mid_y, pts[71:54], pt_gain_q);
    ax = s_top_x - rx; ay = s_top_y - ry;
    bx = s_mid_x - rx; by = s_mid_y - ry;
    na = ax * ax + ay * ay;
    nb = bx * bx + by * by;
    det = 2 * (ax * by - ay * bx);
    if (det == 0) begin
      cx = s_cx; cy = s_cy; rad = s_rad;
    end else begin
      wax = ax; way = ay; wbx = bx; wby = by; wna = na; wnb = nb;
      ox = div_nearest(wby * wna - way * wnb, det);
      oy = div_nearest(wax * wnb - wbx * wna, det);
      qx = clip(ox, -RAD_LIM, RAD_LIM);
      qy = clip(oy, -RAD_LIM, RAD_LIM);
      rad = root_nearest(qx * qx + qy * qy);
      if (rad > 16777215) rad = 16777215;
      cx = clip(rx + ox, -8388608, 8388607);
      cy = clip(ry + oy, -8388608, 8388607);
    end
    s_cx = smooth_step(s_cx, cx, cir_gain_q);
    s_cy = smooth_step(s_cy, cy, cir_gain_q);
    s_rad = smooth_step(s_rad, rad, cir_gain_q);
    c.cx = s_cx[23:0];
    c.cy = s_cy[23:0];
    c.rad = s_rad[23:0];
    c.col = (det == 0);
    return c;
  endfunction

  // ---------------------------------------------------------------- helpers
  function automatic int gap_len();
    if (calm) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(15, 70);
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  task automatic send_points(longint tx, longint ty, longint mx, longint my);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {my[17:0], mx[17:0], ty[17:0], tx[17:0]};
    forever begin
      @(negedge clk);
      if (in_tready) break;
    end
    @(posedge clk);
    circles_due.push_back(predict_circle({my[17:0], mx[17:0], ty[17:0], tx[17:0]}));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    wait (circles_due.size() == 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [scc_pkg::CFG_IDX_W-1:0] idx, longint val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[scc_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      scc_pkg::CFG_ROOT_X:      root_x_q = val & 64'h3FF;
      scc_pkg::CFG_ROOT_Y:      root_y_q = val & 64'h3FF;
      scc_pkg::CFG_POINT_GAIN:  pt_gain_q = val & 64'h1FFFF;
      scc_pkg::CFG_CIRCLE_GAIN: cir_gain_q = val & 64'h1FFFF;
      default: ;
    endcase
  endtask

  task automatic set_regs(longint rx, longint ry, longint pg, longint cg);
    drain();
    write_reg(scc_pkg::CFG_ROOT_X, rx);
    write_reg(scc_pkg::CFG_ROOT_Y, ry);
    write_reg(scc_pkg::CFG_POINT_GAIN, pg);
    write_reg(scc_pkg::CFG_CIRCLE_GAIN, cg);
  endtask

  function automatic longint pick_gain();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65536;
      2: return 131071;
      3: return $urandom_range(65537, 131071);
      default: return $urandom_range(1, 65536);
    endcase
  endfunction

  // ---------------------------------------------------------------- result side
  always @(posedge clk) begin
    circle_t want;
    if (out_tvalid && out_tready) begin
      if (circles_due.size() == 0) begin
        $error("result transaction with nothing expected");
        fails++;
      end else begin
        want = circles_due.pop_front();
        if (out_tdata[23:0] !== want.cx) begin
          $error("ctr_x expected %0h got %0h", want.cx, out_tdata[23:0]);
          fails++;
        end
        if (out_tdata[47:24] !== want.cy) begin
          $error("ctr_y expected %0h got %0h", want.cy, out_tdata[47:24]);
          fails++;
        end
        if (out_tdata[71:48] !== want.rad) begin
          $error("radius expected %0h got %0h", want.rad, out_tdata[71:48]);
          fails++;
        end
        if (out_tuser[0] !== want.col) begin
          $error("collinear expected %0b got %0b", want.col, out_tuser[0]);
          fails++;
        end
      end
    end
    // receiver stalls: long hold on request, otherwise random gaps
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      hold_cycles <= gap_len();
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_reset_values();
    send_points(100 << 8, 150 << 8, 150 << 8, 200 << 8);
    send_points(COORD_MAX, 0, 0, COORD_MAX);
    send_points(300 << 8, 100 << 8, 250 << 8, 180 << 8);
  endtask

  task automatic test_corners();
    longint rx, ry;
    set_regs(202, 269, 65536, 65536);
    rx = 202 << 8; ry = 269 << 8;
    send_points(rx, ry, 400 << 8, 100 << 8);          // top on the root
    send_points(500 << 8, 300 << 8, 500 << 8, 300 << 8); // top equals mid
    send_points(rx + 256, ry + 256, rx + 512, ry + 512); // on a line with root
    send_points(rx + 256, ry + 256, rx + 512, ry + 513); // far center
    send_points(0, 0, COORD_MAX, COORD_MAX);
    send_points(COORD_MAX, COORD_MAX, 0, 0);
    send_points(0, COORD_MAX, COORD_MAX, 0);
    set_regs(0, 0, 65536, 65536);
    send_points(COORD_MAX, 0, 0, COORD_MAX);
    send_points(1, 0, 0, 1);
    send_points(0, 0, 100, 200);                      // top on the root at origin
    set_regs(1023, 1023, 131071, 131071);
    send_points(0, 0, COORD_MAX, 0);
    send_points(0, COORD_MAX, 5, 7);
    send_points(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
  endtask

  task automatic test_gain_edges();
    set_regs(512, 512, 0, 65536);                     // points frozen
    send_points(COORD_MAX, 0, 1000, 2000);
    send_points(0, COORD_MAX, 3000, 4000);
    set_regs(512, 512, 65536, 0);                     // circle frozen
    send_points(100 << 8, 200 << 8, 300 << 8, 250 << 8);
    send_points(700 << 8, 900 << 8, 50 << 8, 600 << 8);
    set_regs(512, 512, 1, 1);
    send_points(COORD_MAX, COORD_MAX, 0, COORD_MAX);
  endtask

  task automatic test_backpressure();
    set_regs(202, 269, 6554, 6554);
    // set the hold away from the receiver's clock edge
    @(negedge clk);
    hold_cycles = 800;
    repeat (6) send_points($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                           $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
  endtask

  task automatic test_random_phases();
    longint rx, ry, tx, ty, mx, my, k;
    for (int ph = 0; ph < 8; ph++) begin
      rx = (ph == 0) ? 0 : ((ph == 1) ? 1023 : $urandom_range(0, 1023));
      ry = (ph == 0) ? 1023 : ((ph == 1) ? 0 : $urandom_range(0, 1023));
      set_regs(rx, ry, (ph < 3) ? 65536 : pick_gain(), (ph < 2) ? 65536 : pick_gain());
      calm = (ph == 5);
      for (int i = 0; i < 230; i++) begin
        tx = $urandom_range(0, COORD_MAX); ty = $urandom_range(0, COORD_MAX);
        mx = $urandom_range(0, COORD_MAX); my = $urandom_range(0, COORD_MAX);
        case ($urandom_range(0, 5))
          0: begin mx = tx; my = ty; end
          1: begin tx = rx << 8; ty = ry << 8; end
          2: begin
            k = $urandom_range(1, 60);
            tx = clip((rx << 8) + k * 256, 0, COORD_MAX);
            ty = clip((ry << 8) + k * 128, 0, COORD_MAX);
            mx = clip((rx << 8) + 2 * k * 256, 0, COORD_MAX);
            my = clip((ry << 8) + 2 * k * 128 + $urandom_range(0, 2), 0, COORD_MAX);
          end
          3: begin
            tx = clip((rx << 8) + longint'($urandom_range(0, 4000)) - 2000, 0, COORD_MAX);
            ty = clip((ry << 8) + longint'($urandom_range(0, 4000)) - 2000, 0, COORD_MAX);
          end
          default: ;
        endcase
        send_points(tx, ty, mx, my);
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    root_x_q = scc_pkg::ROOT_X_RST; root_y_q = scc_pkg::ROOT_Y_RST;
    pt_gain_q = scc_pkg::GAIN_RST; cir_gain_q = scc_pkg::GAIN_RST;
    s_top_x = 0; s_top_y = 0; s_mid_x = 0; s_mid_y = 0;
    s_cx = 0; s_cy = 0; s_rad = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_corners();
    test_gain_edges();
    test_backpressure();
    test_random_phases();
    in_tvalid <= 1'b0;
    wait (circles_due.size() == 0);
    repeat (300) @(posedge clk);
    if (fails == 0)
      $display("tb_smoothed_three_point_circumcircle_unit OK");
    else
      $display("tb_smoothed_three_point_circumcircle_unit NOT OK");
    $finish;
  end

endmodule
